// ----- hdl/lfd_pkg.sv -----
// ----------------------------------------------------------------------------
// Lamp feedback debouncer package
// Widths, register indexes and threshold helper shared by the debouncer files.
// ----------------------------------------------------------------------------
package lfd_pkg;

  localparam int VEC_W        = 16;  // bits per feedback vector
  localparam int CNT_W        = 8;   // change counter and threshold width
  localparam int CFG_IDX_W    = 8;   // config register index width
  localparam int LFD_CHANNELS = 16;  // default debounced channels per vector

  localparam logic [CNT_W-1:0] SC_RISE_RESET   = CNT_W'(5);
  localparam logic [CNT_W-1:0] SC_FALL_RESET   = CNT_W'(20);
  localparam logic [CNT_W-1:0] VOLT_RISE_RESET = CNT_W'(2);
  localparam logic [CNT_W-1:0] VOLT_FALL_RESET = CNT_W'(21);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SC_RISE   = CFG_IDX_W'(0),
    REG_SC_FALL   = CFG_IDX_W'(1),
    REG_VOLT_RISE = CFG_IDX_W'(2),
    REG_VOLT_FALL = CFG_IDX_W'(3)
  } cfg_reg_t;

  typedef struct packed {
    logic [CNT_W-1:0] rise;
    logic [CNT_W-1:0] fall;
  } thresh_t;

  // A zero threshold behaves as one.
  function automatic logic [CNT_W-1:0] eff_threshold(input logic [CNT_W-1:0] t);
    eff_threshold = (t == '0) ? CNT_W'(1) : t;
  endfunction

endpackage

// ----- hdl/lfd_in_if.sv -----
// ----------------------------------------------------------------------------
// Sample channel
// Valid/ready channel carrying the four raw feedback vectors of one scan tick.
// ----------------------------------------------------------------------------
interface lfd_in_if import lfd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [VEC_W-1:0] switch_sample;
  logic [VEC_W-1:0] current_sample;
  logic [VEC_W-1:0] green_sample;
  logic [VEC_W-1:0] red_sample;

  modport source (output valid, switch_sample, current_sample, green_sample, red_sample,
                  input ready);
  modport sink (input valid, switch_sample, current_sample, green_sample, red_sample,
                output ready);
endinterface

// ----- hdl/lfd_out_if.sv -----
// ----------------------------------------------------------------------------
// Stable state channel
// Valid/ready channel carrying the four debounced vectors after one tick.
// ----------------------------------------------------------------------------
interface lfd_out_if import lfd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [VEC_W-1:0] switch_stable;
  logic [VEC_W-1:0] current_stable;
  logic [VEC_W-1:0] green_stable;
  logic [VEC_W-1:0] red_stable;

  modport source (output valid, switch_stable, current_stable, green_stable, red_stable,
                  input ready);
  modport sink (input valid, switch_stable, current_stable, green_stable, red_stable,
                output ready);
endinterface

// ----- hdl/lfd_cfg_if.sv -----
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface lfd_cfg_if import lfd_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CNT_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- hdl/lfd_group.sv -----
// ----------------------------------------------------------------------------
// Debounce group
// Stable bits and change counters for one feedback vector; one update per tick.
// ----------------------------------------------------------------------------
module lfd_group import lfd_pkg::*; #(
  parameter int CHANNELS = LFD_CHANNELS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             upd,
  input  logic [VEC_W-1:0] sample,
  input  thresh_t          thresh,
  output logic [VEC_W-1:0] stable
);

  localparam int ACTIVE = (CHANNELS < 1) ? 1 : ((CHANNELS < VEC_W) ? CHANNELS : VEC_W);

  logic [CNT_W-1:0] rise_eff;
  logic [CNT_W-1:0] fall_eff;

  assign rise_eff = eff_threshold(thresh.rise);
  assign fall_eff = eff_threshold(thresh.fall);

  for (genvar b = 0; b < ACTIVE; b++) begin : g_chan
    logic [CNT_W-1:0] cnt;
    logic [CNT_W-1:0] cnt_inc;
    logic [CNT_W-1:0] lim;
    logic             stab;
    logic             differ;
    logic             hit;

    assign differ  = sample[b] ^ stab;
    assign cnt_inc = cnt + CNT_W'(1);
    assign lim     = stab ? fall_eff : rise_eff;
    assign hit     = (cnt_inc >= lim);

    always_ff @(posedge clk) begin
      if (rst) begin
        cnt  <= '0;
        stab <= 1'b0;
      end else if (upd) begin
        if (!differ) begin
          cnt <= '0;
        end else if (hit) begin
          // flip and restart the count
          cnt  <= '0;
          stab <= ~stab;
        end else begin
          cnt <= cnt_inc;
        end
      end
    end

    assign stable[b] = stab;
  end

  if (ACTIVE < VEC_W) begin : g_pad
    assign stable[VEC_W-1:ACTIVE] = '0;
  end

endmodule

// ----- hdl/lamp_feedback_debouncer.sv -----
// ----------------------------------------------------------------------------
// Lamp feedback debouncer
// Four-vector asymmetric counter debouncer for lamp switch, current and
// voltage feedback, with programmable rise and fall thresholds.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle while states.ready holds; all channels update in
// parallel in one pass between the sample register and the stable-state register,
// as the sample word advances once any pending stable word has been taken.
// Reset: synchronous rst clears stable bits, counters and valid flags and
// loads thresholds 5/20 (switch/current) and 2/21 (voltage).
module lamp_feedback_debouncer import lfd_pkg::*; #(
  parameter int CHANNELS = LFD_CHANNELS
) (
  input  logic       clk,
  input  logic       rst,
  lfd_cfg_if.sink    cfg,
  lfd_in_if.sink     samples,
  lfd_out_if.source  states
);

  thresh_t sc_thresh;
  thresh_t volt_thresh;

  logic             in_valid;
  logic [VEC_W-1:0] in_switch;
  logic [VEC_W-1:0] in_current;
  logic [VEC_W-1:0] in_green;
  logic [VEC_W-1:0] in_red;
  logic             out_valid;
  logic             advance;

  // config writes
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sc_thresh.rise   <= SC_RISE_RESET;
      sc_thresh.fall   <= SC_FALL_RESET;
      volt_thresh.rise <= VOLT_RISE_RESET;
      volt_thresh.fall <= VOLT_FALL_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_SC_RISE:   sc_thresh.rise   <= cfg.data;
        REG_SC_FALL:   sc_thresh.fall   <= cfg.data;
        REG_VOLT_RISE: volt_thresh.rise <= cfg.data;
        REG_VOLT_FALL: volt_thresh.fall <= cfg.data;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // advance the sample word once any pending stable word has been taken
  assign advance       = in_valid && (!out_valid || states.ready);
  assign samples.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (samples.valid && samples.ready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (samples.valid && samples.ready) begin
      in_switch  <= samples.switch_sample;
      in_current <= samples.current_sample;
      in_green   <= samples.green_sample;
      in_red     <= samples.red_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (states.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign states.valid = out_valid;

  // stable bits hold while the result waits, so they serve as the result register
  lfd_group #(.CHANNELS(CHANNELS)) u_switch (
    .clk(clk), .rst(rst), .upd(advance), .sample(in_switch),
    .thresh(sc_thresh), .stable(states.switch_stable)
  );

  lfd_group #(.CHANNELS(CHANNELS)) u_current (
    .clk(clk), .rst(rst), .upd(advance), .sample(in_current),
    .thresh(sc_thresh), .stable(states.current_stable)
  );

  lfd_group #(.CHANNELS(CHANNELS)) u_green (
    .clk(clk), .rst(rst), .upd(advance), .sample(in_green),
    .thresh(volt_thresh), .stable(states.green_stable)
  );

  lfd_group #(.CHANNELS(CHANNELS)) u_red (
    .clk(clk), .rst(rst), .upd(advance), .sample(in_red),
    .thresh(volt_thresh), .stable(states.red_stable)
  );

endmodule
